// ===== hdl/fbsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Flash bank select check package
// Shared widths, bank bounds, register indexes, status codes and types.
// ----------------------------------------------------------------------------
package fbsc_pkg;

	localparam int HIGH_BANK_SLOTS = 20;
	localparam int HIGH_OUT_W      = 20;
	localparam int LOW_BANKS       = 6;
	localparam int MID_BANKS       = 2;
	localparam int ADDR_W          = 33;
	localparam int OFFS_W          = 32;
	localparam int OPS_W           = 5;
	localparam int STATUS_W        = 3;
	localparam int SIZE_W          = 22;
	localparam int CFG_IDX_W       = 8;
	localparam int CFG_DATA_W      = 8;
	localparam int IN_TDATA_W      = 104;
	localparam int OUT_TDATA_W     = 56;

	localparam int unsigned KB         = 1024;
	localparam int unsigned MID_START  = 256 * KB;
	localparam int unsigned HIGH_START = 512 * KB;
	localparam int unsigned BANK_BYTES = 128 * KB;

	localparam logic [2:0] LOW_LAYOUT_OK = 3'd6;
	localparam logic       MID_LAYOUT_OK = 1'b0;

	localparam logic [3:0] SIZE_CODE_1M5 = 4'd5;
	localparam logic [3:0] SIZE_CODE_2M  = 4'd7;
	localparam logic [3:0] SIZE_CODE_3M  = 4'd11;

	localparam logic [SIZE_W-1:0] SIZE_1M5 = SIZE_W'(HIGH_START + 8 * BANK_BYTES);
	localparam logic [SIZE_W-1:0] SIZE_2M  = SIZE_W'(HIGH_START + 12 * BANK_BYTES);
	localparam logic [SIZE_W-1:0] SIZE_3M  = SIZE_W'(HIGH_START + 20 * BANK_BYTES);

	localparam logic [OPS_W-1:0] WRITE_OPS = 5'b01011;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_LAYOUT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MID_LAYOUT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_CODE  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WRITABLE   = 8'd3;

	localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
	localparam logic [STATUS_W-1:0] ST_LAYOUT       = 3'd1;
	localparam logic [STATUS_W-1:0] ST_SIZE         = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE        = 3'd3;
	localparam logic [STATUS_W-1:0] ST_NOT_WRITABLE = 3'd4;
	localparam logic [STATUS_W-1:0] ST_OVERLAP      = 3'd5;

	typedef struct packed {
		logic [2:0] low_layout_code;
		logic       mid_layout_code;
		logic [3:0] size_code;
		logic       flash_writable;
	} cfg_t;

	typedef struct packed {
		logic [OFFS_W-1:0] dest_offset;
		logic [OFFS_W-1:0] src_offset;
		logic [OFFS_W-1:0] byte_count;
		logic [OPS_W-1:0]  op_mask;
	} req_t;

	typedef struct packed {
		logic [LOW_BANKS-1:0]       low;
		logic [MID_BANKS-1:0]       mid;
		logic [HIGH_BANK_SLOTS-1:0] high;
	} bank_sel_t;

	typedef struct packed {
		logic [STATUS_W-1:0]   status;
		logic [LOW_BANKS-1:0]  low_banks;
		logic [MID_BANKS-1:0]  mid_banks;
		logic [HIGH_OUT_W-1:0] high_banks;
		logic [SIZE_W-1:0]     flash_bytes;
	} result_t;

	function automatic logic [ADDR_W-1:0] low_lo(input int unsigned i);
		logic [ADDR_W-1:0] v;
		case (i)
			0: v = ADDR_W'(0);
			1: v = ADDR_W'(16 * KB);
			2: v = ADDR_W'(32 * KB);
			3: v = ADDR_W'(80 * KB);
			4: v = ADDR_W'(128 * KB);
			default: v = ADDR_W'(192 * KB);
		endcase
		return v;
	endfunction

	function automatic logic [ADDR_W-1:0] low_hi(input int unsigned i);
		logic [ADDR_W-1:0] v;
		case (i)
			0: v = ADDR_W'(16 * KB - 1);
			1: v = ADDR_W'(32 * KB - 1);
			2: v = ADDR_W'(80 * KB - 1);
			3: v = ADDR_W'(128 * KB - 1);
			4: v = ADDR_W'(192 * KB - 1);
			default: v = ADDR_W'(256 * KB - 1);
		endcase
		return v;
	endfunction

endpackage

// ===== hdl/fbsc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the layout, size and write permission fields written over the
// configuration channel.
// ----------------------------------------------------------------------------
module fbsc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fbsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbsc_pkg::CFG_DATA_W-1:0] cfg_data,
	output fbsc_pkg::cfg_t                cfg
);
	import fbsc_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_layout_code <= LOW_LAYOUT_OK;
			cfg_q.mid_layout_code <= MID_LAYOUT_OK;
			cfg_q.size_code       <= SIZE_CODE_2M;
			cfg_q.flash_writable  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LOW_LAYOUT: cfg_q.low_layout_code <= cfg_data[2:0];
				REG_MID_LAYOUT: cfg_q.mid_layout_code <= cfg_data[0];
				REG_SIZE_CODE:  cfg_q.size_code       <= cfg_data[3:0];
				REG_WRITABLE:   cfg_q.flash_writable  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hdl/fbsc_bank_decode.sv =====
// ----------------------------------------------------------------------------
// Bank decoder
// Marks every low, mid and high bank that an inclusive address range touches.
// ----------------------------------------------------------------------------
module fbsc_bank_decode (
	input  logic [fbsc_pkg::ADDR_W-1:0] first,
	input  logic [fbsc_pkg::ADDR_W-1:0] last,
	output fbsc_pkg::bank_sel_t         sel
);
	import fbsc_pkg::*;

	for (genvar i = 0; i < LOW_BANKS; i++) begin : g_low
		assign sel.low[i] = (first <= low_hi(i)) && (last >= low_lo(i));
	end

	for (genvar i = 0; i < MID_BANKS; i++) begin : g_mid
		localparam logic [ADDR_W-1:0] BLO = ADDR_W'(MID_START + i * BANK_BYTES);
		localparam logic [ADDR_W-1:0] BHI = BLO + ADDR_W'(BANK_BYTES - 1);
		assign sel.mid[i] = (first <= BHI) && (last >= BLO);
	end

	for (genvar i = 0; i < HIGH_BANK_SLOTS; i++) begin : g_high
		localparam logic [ADDR_W-1:0] BLO = ADDR_W'(HIGH_START + i * BANK_BYTES);
		localparam logic [ADDR_W-1:0] BHI = BLO + ADDR_W'(BANK_BYTES - 1);
		assign sel.high[i] = (first <= BHI) && (last >= BLO);
	end

endmodule

// ===== hdl/fbsc_check.sv =====
// ----------------------------------------------------------------------------
// Request checker
// Validates one copy request against the flash layout, size and write flag,
// and builds the destination bank masks with the source overlap test.
// ----------------------------------------------------------------------------
module fbsc_check (
	input  fbsc_pkg::cfg_t    cfg,
	input  fbsc_pkg::req_t    req,
	output fbsc_pkg::result_t res
);
	import fbsc_pkg::*;

	logic [ADDR_W-1:0]     dest_first;
	logic [ADDR_W-1:0]     dest_last;
	logic [ADDR_W-1:0]     src_first;
	logic [ADDR_W-1:0]     src_last;
	logic [ADDR_W-1:0]     size_wide;
	logic [SIZE_W-1:0]     size;
	logic                  size_known;
	logic                  layout_ok;
	logic                  range_bad;
	logic                  write_bad;
	logic                  overlap;
	logic [HIGH_OUT_W-1:0] dest_high_out;
	bank_sel_t             dest_sel;
	bank_sel_t             src_sel;

	assign dest_first = {1'b0, req.dest_offset};
	assign src_first  = {1'b0, req.src_offset};
	assign dest_last  = dest_first + {1'b0, req.byte_count};
	assign src_last   = src_first + {1'b0, req.byte_count};

	assign layout_ok = (cfg.low_layout_code == LOW_LAYOUT_OK) &&
		(cfg.mid_layout_code == MID_LAYOUT_OK);

	always_comb begin
		size_known = 1'b1;
		case (cfg.size_code)
			SIZE_CODE_1M5: size = SIZE_1M5;
			SIZE_CODE_2M:  size = SIZE_2M;
			SIZE_CODE_3M:  size = SIZE_3M;
			default: begin
				size       = '0;
				size_known = 1'b0;
			end
		endcase
	end

	assign size_wide = ADDR_W'(size);
	assign range_bad = (dest_first > size_wide) || (dest_last > size_wide) ||
		(req.dest_offset[2:0] != 3'b000) || (req.byte_count[2:0] != 3'b000);
	assign write_bad = ((req.op_mask & WRITE_OPS) != '0) && !cfg.flash_writable;

	fbsc_bank_decode u_dest_decode (
		.first (dest_first),
		.last  (dest_last),
		.sel   (dest_sel)
	);

	fbsc_bank_decode u_src_decode (
		.first (src_first),
		.last  (src_last),
		.sel   (src_sel)
	);

	assign overlap = (|(dest_sel.low & src_sel.low)) || (|(dest_sel.mid & src_sel.mid)) ||
		(|(dest_sel.high & src_sel.high));

	if (HIGH_BANK_SLOTS >= HIGH_OUT_W) begin : g_high_trunc
		assign dest_high_out = dest_sel.high[HIGH_OUT_W-1:0];
	end else begin : g_high_ext
		assign dest_high_out = {{(HIGH_OUT_W - HIGH_BANK_SLOTS){1'b0}}, dest_sel.high};
	end

	always_comb begin
		res = '0;
		if (!layout_ok) begin
			res.status = ST_LAYOUT;
		end else if (!size_known) begin
			res.status = ST_SIZE;
		end else begin
			res.flash_bytes = size;
			if (range_bad) begin
				res.status = ST_RANGE;
			end else if (req.op_mask != '0) begin
				if (write_bad) begin
					res.status = ST_NOT_WRITABLE;
				end else if (overlap) begin
					res.status = ST_OVERLAP;
				end else begin
					res.status     = ST_OK;
					res.low_banks  = dest_sel.low;
					res.mid_banks  = dest_sel.mid;
					res.high_banks = dest_high_out;
				end
			end
		end
	end

endmodule

// ===== hdl/flash_bank_select_check_unit.sv =====
// ----------------------------------------------------------------------------
// Flash bank select check unit
// Checks flash copy requests and returns the destination bank masks.
//
// A request beat arrives on the s_ group and one result beat leaves on the
// m_ group for every request. The configuration channel writes the layout,
// size and write permission registers; it is always ready and must only be
// used while no request is in flight.
// A request beat is registered in the input register when it is accepted,
// checked there and registered as a result in the result register, which
// offers the result beat. One request per cycle is sustained while m_tready
// stays high: the input register and the result register form a two-stage
// pipeline with the check logic between them, and s_tready stays high while
// the result register is being drained.
// When m_tready is low the result is held and the input register keeps one
// more request; s_tready drops once both stages are full.
// Reset empties both stages and loads the register defaults: low layout 6,
// mid layout 0, size code 7 (2 MB) and flash not writable.
// ----------------------------------------------------------------------------
module flash_bank_select_check_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// dest_offset[31:0], src_offset[63:32], byte_count[95:64], op_mask[100:96]
	input  logic [fbsc_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// status[2:0], low_banks[8:3], mid_banks[10:9], high_banks[30:11],
	// flash_bytes[52:31]
	output logic [fbsc_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fbsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fbsc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import fbsc_pkg::*;

	cfg_t    cfg;
	req_t    req_in;
	req_t    req_s1;
	result_t res;
	result_t res_s2;
	logic    valid_s1;
	logic    valid_s2;
	logic    adv_s1;

	fbsc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign req_in.dest_offset = s_tdata[31:0];
	assign req_in.src_offset  = s_tdata[63:32];
	assign req_in.byte_count  = s_tdata[95:64];
	assign req_in.op_mask     = s_tdata[100:96];

	assign adv_s1   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1 <= req_in;
		end
		if (valid_s1 && adv_s1) begin
			res_s2 <= res;
		end
	end

	fbsc_check u_check (
		.cfg (cfg),
		.req (req_s1),
		.res (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000, res_s2.flash_bytes, res_s2.high_banks, res_s2.mid_banks,
		res_s2.low_banks, res_s2.status};

`ifndef ASSERT_OFF
	a_banks_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.status != ST_OK) |->
		(res_s2.low_banks == '0) && (res_s2.mid_banks == '0) && (res_s2.high_banks == '0))
		else $error("bank mask set on a failed request");

	a_no_size_on_cfg_error: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && ((res_s2.status == ST_LAYOUT) || (res_s2.status == ST_SIZE)) |->
		(res_s2.flash_bytes == '0))
		else $error("flash size reported with a layout or size error");

	a_stage_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s1 |=> valid_s2)
		else $error("checked request did not reach the result register");

	a_stalled_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(req_s1))
		else $error("stalled request lost from the input register");
`endif

endmodule
